>>> hdl/hrs_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request scanner package
// Phase codes, token kinds, character constants and the result bundle shared
// by the scanner step logic and the top level.
// ----------------------------------------------------------------------------
package hrs_pkg;

    localparam int LENGTH_WIDTH_DEF = 32;
    localparam int BODY_LEN_W       = 32;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [3:0] NAME_LEN   = 4'd14;
    localparam logic [3:0] MATCH_FAIL = 4'd15;

    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;
    localparam logic [1:0] KIND_BODY  = 2'd3;

    typedef enum logic [3:0] {
        PH_RL         = 4'd0,
        PH_RL_CR      = 4'd1,
        PH_LINE       = 4'd2,
        PH_NAME       = 4'd3,
        PH_SEP_BLANK  = 4'd4,
        PH_SEP_COLON  = 4'd5,
        PH_VALUE      = 4'd6,
        PH_VALUE_REST = 4'd7,
        PH_LINE_CR    = 4'd8,
        PH_END_CR     = 4'd9,
        PH_BODY       = 4'd10
    } t_phase;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic                  byte_valid;
        logic [1:0]            token_kind;
        logic                  token_last;
        logic                  is_length_header;
        logic                  headers_done;
        logic [BODY_LEN_W-1:0] content_len;
        logic                  length_overflow;
        logic                  request_done;
    } t_result;

    // Characters of the Content-Length header name, by match position
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6f; // o
            4'd2:    ch = 8'h6e; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6e; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2d; // -
            4'd8:    ch = 8'h4c; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6e; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> hdl/hrs_step.sv
// ----------------------------------------------------------------------------
// HTTP request scanner step
// Next-state and result logic for one byte: resolves separator and CR/LF
// phases, tags token bytes, matches the length header, accumulates digits.
// ----------------------------------------------------------------------------
module hrs_step #(
    parameter int LENGTH_WIDTH = hrs_pkg::LENGTH_WIDTH_DEF
) (
    input  logic [7:0]              i_byte,
    input  hrs_pkg::t_phase         i_phase,
    input  logic [3:0]              i_match,
    input  logic [LENGTH_WIDTH-1:0] i_count,
    input  logic [LENGTH_WIDTH-1:0] i_remain,
    input  logic                    i_ovf,
    input  logic                    i_lflag,
    output hrs_pkg::t_phase         o_phase,
    output logic [3:0]              o_match,
    output logic [LENGTH_WIDTH-1:0] o_count,
    output logic [LENGTH_WIDTH-1:0] o_remain,
    output logic                    o_ovf,
    output logic                    o_lflag,
    output logic                    o_emit,
    output hrs_pkg::t_result        o_result
);

    logic                      blank;
    logic                      eol;
    logic                      digit;
    logic                      go;
    logic                      clr;
    hrs_pkg::t_phase           eff;
    logic [LENGTH_WIDTH+3:0]   prod;
    logic [LENGTH_WIDTH+31:0]  len_ext;

    assign blank = (i_byte == hrs_pkg::CH_SP) || (i_byte == hrs_pkg::CH_TAB);
    assign eol   = (i_byte == hrs_pkg::CH_CR) || (i_byte == hrs_pkg::CH_LF);
    assign digit = (i_byte >= hrs_pkg::CH_ZERO) && (i_byte <= hrs_pkg::CH_NINE);

    // count * 10 + digit; anything above the counter width means saturation
    assign prod = {1'b0, i_count, 3'b000} + {3'b000, i_count, 1'b0}
                + {{(LENGTH_WIDTH){1'b0}}, i_byte[3:0]};

    always_comb begin
        o_phase  = i_phase;
        o_match  = i_match;
        o_count  = i_count;
        o_remain = i_remain;
        o_ovf    = i_ovf;
        o_lflag  = i_lflag;
        o_emit   = 1'b0;
        o_result = '0;
        clr      = 1'b0;
        go       = 1'b1;
        eff      = i_phase;
        len_ext  = '0;

        // separator and line-break phases: drop the byte or hand it on
        case (i_phase)
            hrs_pkg::PH_RL_CR, hrs_pkg::PH_LINE_CR: begin
                o_phase = hrs_pkg::PH_LINE;
                if (i_byte == hrs_pkg::CH_LF) begin
                    go = 1'b0;
                end else begin
                    eff = hrs_pkg::PH_LINE;
                end
            end
            hrs_pkg::PH_END_CR: begin
                o_phase = (i_remain != '0) ? hrs_pkg::PH_BODY : hrs_pkg::PH_RL;
                if (i_byte == hrs_pkg::CH_LF) begin
                    go = 1'b0;
                end else begin
                    eff = o_phase;
                end
            end
            hrs_pkg::PH_SEP_BLANK: begin
                if (blank) begin
                    go = 1'b0;
                end else if (i_byte == hrs_pkg::CH_COLON) begin
                    o_phase = hrs_pkg::PH_SEP_COLON;
                    go      = 1'b0;
                end else begin
                    eff = hrs_pkg::PH_VALUE;
                end
            end
            hrs_pkg::PH_SEP_COLON: begin
                if (blank) begin
                    go = 1'b0;
                end else begin
                    eff = hrs_pkg::PH_VALUE;
                end
            end
            hrs_pkg::PH_RL, hrs_pkg::PH_LINE, hrs_pkg::PH_NAME, hrs_pkg::PH_VALUE,
            hrs_pkg::PH_VALUE_REST, hrs_pkg::PH_BODY: begin
                eff = i_phase;
            end
            default: begin
                eff = hrs_pkg::PH_RL;
            end
        endcase

        // a line that is not blank opens a header name
        if (go && eff == hrs_pkg::PH_LINE && !eol) begin
            o_match = '0;
            o_lflag = 1'b0;
            eff     = hrs_pkg::PH_NAME;
        end

        if (go) begin
            case (eff)
                hrs_pkg::PH_RL: begin
                    o_emit = 1'b1;
                    o_result.token_kind = hrs_pkg::KIND_REQ;
                    if (eol) begin
                        o_phase = (i_byte == hrs_pkg::CH_CR) ? hrs_pkg::PH_RL_CR
                                                             : hrs_pkg::PH_LINE;
                        o_result.token_last = 1'b1;
                    end else begin
                        o_phase = hrs_pkg::PH_RL;
                        o_result.out_byte   = i_byte;
                        o_result.byte_valid = 1'b1;
                    end
                end
                hrs_pkg::PH_LINE: begin
                    // blank line: end of the header block
                    o_emit   = 1'b1;
                    o_remain = i_count;
                    o_result.token_kind   = hrs_pkg::KIND_NAME;
                    o_result.token_last   = 1'b1;
                    o_result.headers_done = 1'b1;
                    o_result.request_done = (i_count == '0);
                    clr = (i_count == '0);
                    if (i_byte == hrs_pkg::CH_CR) begin
                        o_phase = hrs_pkg::PH_END_CR;
                    end else begin
                        o_phase = (i_count == '0) ? hrs_pkg::PH_RL : hrs_pkg::PH_BODY;
                    end
                end
                hrs_pkg::PH_NAME: begin
                    o_emit = 1'b1;
                    o_result.token_kind = hrs_pkg::KIND_NAME;
                    if (i_byte == hrs_pkg::CH_COLON || blank) begin
                        o_lflag = (o_match == hrs_pkg::NAME_LEN);
                        if (o_lflag) begin
                            o_count = '0;
                            o_ovf   = 1'b0;
                        end
                        o_phase = (i_byte == hrs_pkg::CH_COLON) ? hrs_pkg::PH_SEP_COLON
                                                                : hrs_pkg::PH_SEP_BLANK;
                        o_result.token_last       = 1'b1;
                        o_result.is_length_header = o_lflag;
                    end else if (eol) begin
                        o_lflag = 1'b0;
                        o_phase = (i_byte == hrs_pkg::CH_CR) ? hrs_pkg::PH_LINE_CR
                                                             : hrs_pkg::PH_LINE;
                        o_result.token_last = 1'b1;
                    end else begin
                        o_phase = hrs_pkg::PH_NAME;
                        if (o_match < hrs_pkg::NAME_LEN
                            && i_byte == hrs_pkg::name_char(o_match)) begin
                            o_match = o_match + 4'd1;
                        end else begin
                            o_match = hrs_pkg::MATCH_FAIL;
                        end
                        o_result.out_byte   = i_byte;
                        o_result.byte_valid = 1'b1;
                    end
                end
                hrs_pkg::PH_VALUE, hrs_pkg::PH_VALUE_REST: begin
                    o_emit = 1'b1;
                    o_result.token_kind       = hrs_pkg::KIND_VALUE;
                    o_result.is_length_header = i_lflag;
                    if (eol) begin
                        o_phase = (i_byte == hrs_pkg::CH_CR) ? hrs_pkg::PH_LINE_CR
                                                             : hrs_pkg::PH_LINE;
                        o_result.token_last = 1'b1;
                    end else begin
                        o_phase = eff;
                        if (eff == hrs_pkg::PH_VALUE && i_lflag) begin
                            if (digit) begin
                                if (prod[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0) begin
                                    o_count = '1;
                                    o_ovf   = 1'b1;
                                end else begin
                                    o_count = prod[LENGTH_WIDTH-1:0];
                                end
                            end else begin
                                // stop accumulating for the rest of this value
                                o_phase = hrs_pkg::PH_VALUE_REST;
                            end
                        end
                        o_result.out_byte   = i_byte;
                        o_result.byte_valid = 1'b1;
                    end
                end
                hrs_pkg::PH_BODY: begin
                    o_emit = 1'b1;
                    o_result.out_byte   = i_byte;
                    o_result.byte_valid = 1'b1;
                    o_result.token_kind = hrs_pkg::KIND_BODY;
                    if (i_remain <= {{(LENGTH_WIDTH-1){1'b0}}, 1'b1}) begin
                        o_result.token_last   = 1'b1;
                        o_result.request_done = 1'b1;
                        o_phase = hrs_pkg::PH_RL;
                        clr     = 1'b1;
                    end else begin
                        o_phase  = hrs_pkg::PH_BODY;
                        o_remain = i_remain - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
                    end
                end
                default: begin
                    o_phase = hrs_pkg::PH_RL;
                end
            endcase
        end

        // report count and overflow as they stand before a request clear
        len_ext = {{(hrs_pkg::BODY_LEN_W){1'b0}}, o_count};
        o_result.content_len     = len_ext[hrs_pkg::BODY_LEN_W-1:0];
        o_result.length_overflow = o_ovf;

        if (clr) begin
            o_count  = '0;
            o_ovf    = 1'b0;
            o_remain = '0;
            o_lflag  = 1'b0;
            o_match  = '0;
        end
    end

endmodule

>>> hdl/http_request_scanner.sv
// ----------------------------------------------------------------------------
// HTTP request scanner
// Tags request-line, header-name, header-value and body bytes, marks token
// ends, decodes Content-Length and counts the body out.
// ----------------------------------------------------------------------------
// Pipeline: the input byte is registered, passes through the step logic, and
//   its result is registered; a full result slot holds the byte in the input
//   register; bytes that only advance the parser give no result.
// Throughput: one byte per cycle unless a result waits on a full slot; the
//   per-byte state update is one pass of the step logic between the two registers.
// Reset: synchronous, active low; parser returns to the request line with
//   length, body count and flags cleared, and both registers empty.
module http_request_scanner #(
    parameter int LENGTH_WIDTH = hrs_pkg::LENGTH_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic [1:0]  o_token_kind,
    output logic        o_token_last,
    output logic        o_is_length_header,
    output logic        o_headers_done,
    output logic [31:0] o_content_len,
    output logic        o_length_overflow,
    output logic        o_request_done
);

    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    hrs_pkg::t_phase         r_phase;
    logic [3:0]              r_match;
    logic [LENGTH_WIDTH-1:0] r_count;
    logic [LENGTH_WIDTH-1:0] r_remain;
    logic                    r_ovf;
    logic                    r_lflag;
    logic                    r_out_valid;
    hrs_pkg::t_result        r_out;

    hrs_pkg::t_phase         n_phase;
    logic [3:0]              n_match;
    logic [LENGTH_WIDTH-1:0] n_count;
    logic [LENGTH_WIDTH-1:0] n_remain;
    logic                    n_ovf;
    logic                    n_lflag;
    logic                    step_emit;
    hrs_pkg::t_result        step_res;

    logic out_free;
    logic adv;

    hrs_step #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_step (
        .i_byte   (r_in_byte),
        .i_phase  (r_phase),
        .i_match  (r_match),
        .i_count  (r_count),
        .i_remain (r_remain),
        .i_ovf    (r_ovf),
        .i_lflag  (r_lflag),
        .o_phase  (n_phase),
        .o_match  (n_match),
        .o_count  (n_count),
        .o_remain (n_remain),
        .o_ovf    (n_ovf),
        .o_lflag  (n_lflag),
        .o_emit   (step_emit),
        .o_result (step_res)
    );

    // the held byte advances unless it has a result and the result slot is full and not being read
    assign out_free = !r_out_valid || i_ready;
    assign adv      = r_in_valid && (!step_emit || out_free);
    assign o_ready  = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hrs_pkg::PH_RL;
            r_match  <= '0;
            r_count  <= '0;
            r_remain <= '0;
            r_ovf    <= 1'b0;
            r_lflag  <= 1'b0;
        end else if (adv) begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_count  <= n_count;
            r_remain <= n_remain;
            r_ovf    <= n_ovf;
            r_lflag  <= n_lflag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && step_emit) begin
            r_out <= step_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_out_byte         = r_out.out_byte;
    assign o_byte_valid       = r_out.byte_valid;
    assign o_token_kind       = r_out.token_kind;
    assign o_token_last       = r_out.token_last;
    assign o_is_length_header = r_out.is_length_header;
    assign o_headers_done     = r_out.headers_done;
    assign o_content_len      = r_out.content_len;
    assign o_length_overflow  = r_out.length_overflow;
    assign o_request_done     = r_out.request_done;

    // body phase is only entered with bytes left to count
    a_body_remain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == hrs_pkg::PH_BODY |-> r_remain != '0)
        else $error("body phase with zero remaining count");

    // a result without a token byte only marks a token end
    a_end_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_token_last && o_out_byte == 8'd0)
        else $error("empty result is not a token end");

    // request completion comes with the blank line or the last body byte
    a_req_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_request_done |->
            o_token_last && (o_headers_done || o_token_kind == hrs_pkg::KIND_BODY))
        else $error("request end outside header end or body end");

    // header block end is tagged as a header-name line end
    a_hdr_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_headers_done |->
            o_token_kind == hrs_pkg::KIND_NAME && !o_byte_valid)
        else $error("header block end has wrong tag");

endmodule
